// ----- design/qtm_pkg.sv -----
// Shared widths, pipeline records and the divider step for the TRS-to-matrix unit.
package qtm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = FRAC_BITS + 2;   // quotient bits, ratio is at most 2.0
  localparam int EW        = FRAC_BITS + 3;   // signed matrix entry, range -2.0 .. 2.0
  localparam int PW        = EW + 32;         // entry times scale
  localparam int RW        = PW - FRAC_BITS;  // product after the fraction shift
  localparam int DIV_STEPS = FRAC_BITS + 2;   // two integer steps, then one per fraction bit

  localparam logic [1:0] COL_LAST = 2'd3;

  typedef struct packed {
    logic [63:0]   a;     // remainder, or the pass-through value on the translation column
    logic [QW-1:0] q;
    logic          neg;
    logic          diag;
  } lane_t;

  typedef struct packed {
    logic [63:0] n;
    logic [31:0] scale;
    logic [1:0]  idx;
    logic        zero;
    logic        pass;
    lane_t [2:0] lane;
  } col_t;

  typedef struct packed {
    logic [31:0]             scale;
    logic [1:0]              idx;
    logic                    zero;
    logic                    pass;
    logic [2:0][EW-1:0]      e;
    logic [2:0][31:0]        tr;
  } ent_t;

  typedef struct packed {
    logic [1:0]              idx;
    logic                    zero;
    logic                    pass;
    logic [2:0][PW-1:0]      p;
    logic [2:0][31:0]        tr;
  } prod_t;

  // One restoring step: integer steps subtract in place, fraction steps shift first.
  function automatic lane_t div_step(lane_t l, logic [63:0] b, logic int_step);
    lane_t       r;
    logic [63:0] a2;
    logic [QW-1:0] q2;
    r = l;
    if (int_step) begin
      if (l.a >= b) begin
        r.a = l.a - b;
        r.q = l.q + QW'(1);
      end
    end else begin
      a2 = {l.a[62:0], 1'b0};
      q2 = {l.q[QW-2:0], 1'b0};
      if (a2 >= b) begin
        a2    = a2 - b;
        q2[0] = 1'b1;
      end
      r.a = a2;
      r.q = q2;
    end
    return r;
  endfunction

endpackage

// ----- design/qtm_front.sv -----
// Item stages: quaternion prescale, products, sums, magnitudes, then column issue.
module qtm_front import qtm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_translate_x,
  input  logic [31:0] in_translate_y,
  input  logic [31:0] in_translate_z,
  input  logic [31:0] in_quat_x,
  input  logic [31:0] in_quat_y,
  input  logic [31:0] in_quat_z,
  input  logic [31:0] in_quat_w,
  input  logic [31:0] in_scale_x,
  input  logic [31:0] in_scale_y,
  input  logic [31:0] in_scale_z,
  input  logic        col_en,
  output logic        iss_valid,
  output col_t        iss
);

  logic v1_r, v2_r, v3_r, v4_r, ex_v_r;
  logic rdy1, rdy2, rdy3, rdy4, ex_rdy;
  logic [1:0] ex_cnt_r;

  logic signed [31:0] q1_r [4];
  logic [31:0] sc1_r [3], sc2_r [3], sc3_r [3], sc4_r [3], ex_sc_r [3];
  logic [31:0] tr1_r [3], tr2_r [3], tr3_r [3], tr4_r [3], ex_tr_r [3];
  logic signed [63:0] p2_r [10];
  logic signed [63:0] num3_r [9];
  logic [63:0] n3_r, n4_r, ex_n_r;
  logic [63:0] mag4_r [9], ex_mag_r [9];
  logic [8:0]  neg4_r, ex_neg_r;
  logic        zero4_r, ex_zero_r;

  logic signed [31:0] qin [4];
  logic signed [31:0] qsh [4];
  logic               big;

  assign ex_rdy   = !ex_v_r || (col_en && ex_cnt_r == COL_LAST);
  assign rdy4     = !v4_r || ex_rdy;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    qin[0] = $signed(in_quat_x);
    qin[1] = $signed(in_quat_y);
    qin[2] = $signed(in_quat_z);
    qin[3] = $signed(in_quat_w);
    big = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (qin[i] > 32'sh4000_0000 || qin[i] < -32'sh4000_0000) big = 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      qsh[i] = big ? (qin[i] >>> 1) : qin[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      ex_v_r   <= 1'b0;
      ex_cnt_r <= 2'd0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (ex_rdy) begin
        ex_v_r   <= v4_r;
        ex_cnt_r <= 2'd0;
      end else if (col_en && ex_v_r) begin
        ex_cnt_r <= ex_cnt_r + 2'd1;
      end
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 4; i++) q1_r[i] <= qsh[i];
      sc1_r[0] <= in_scale_x;
      sc1_r[1] <= in_scale_y;
      sc1_r[2] <= in_scale_z;
      tr1_r[0] <= in_translate_x;
      tr1_r[1] <= in_translate_y;
      tr1_r[2] <= in_translate_z;
    end
    if (rdy2) begin
      // order: xx yy zz ww xy xz yz wx wy wz
      p2_r[0] <= q1_r[0] * q1_r[0];
      p2_r[1] <= q1_r[1] * q1_r[1];
      p2_r[2] <= q1_r[2] * q1_r[2];
      p2_r[3] <= q1_r[3] * q1_r[3];
      p2_r[4] <= q1_r[0] * q1_r[1];
      p2_r[5] <= q1_r[0] * q1_r[2];
      p2_r[6] <= q1_r[1] * q1_r[2];
      p2_r[7] <= q1_r[3] * q1_r[0];
      p2_r[8] <= q1_r[3] * q1_r[1];
      p2_r[9] <= q1_r[3] * q1_r[2];
      sc2_r <= sc1_r;
      tr2_r <= tr1_r;
    end
    if (rdy3) begin
      n3_r      <= p2_r[0] + p2_r[1] + p2_r[2] + p2_r[3];
      num3_r[0] <= (p2_r[1] + p2_r[2]) <<< 1;
      num3_r[1] <= (p2_r[4] + p2_r[9]) <<< 1;
      num3_r[2] <= (p2_r[5] - p2_r[8]) <<< 1;
      num3_r[3] <= (p2_r[4] - p2_r[9]) <<< 1;
      num3_r[4] <= (p2_r[0] + p2_r[2]) <<< 1;
      num3_r[5] <= (p2_r[6] + p2_r[7]) <<< 1;
      num3_r[6] <= (p2_r[5] + p2_r[8]) <<< 1;
      num3_r[7] <= (p2_r[6] - p2_r[7]) <<< 1;
      num3_r[8] <= (p2_r[0] + p2_r[1]) <<< 1;
      sc3_r <= sc2_r;
      tr3_r <= tr2_r;
    end
    if (rdy4) begin
      n4_r    <= n3_r;
      zero4_r <= (n3_r == 64'd0);
      for (int i = 0; i < 9; i++) begin
        neg4_r[i] <= num3_r[i][63];
        mag4_r[i] <= num3_r[i][63] ? 64'(-num3_r[i]) : 64'(num3_r[i]);
      end
      sc4_r <= sc3_r;
      tr4_r <= tr3_r;
    end
    if (ex_rdy) begin
      ex_n_r    <= n4_r;
      ex_zero_r <= zero4_r;
      ex_mag_r  <= mag4_r;
      ex_neg_r  <= neg4_r;
      ex_sc_r   <= sc4_r;
      ex_tr_r   <= tr4_r;
    end
  end

  always_comb begin
    iss_valid = ex_v_r;
    iss.n     = ex_n_r;
    iss.idx   = ex_cnt_r;
    iss.zero  = ex_zero_r;
    iss.pass  = (ex_cnt_r == COL_LAST);
    iss.scale = 32'd0;
    for (int i = 0; i < 3; i++) begin
      iss.lane[i].q    = '0;
      iss.lane[i].diag = 1'b0;
      iss.lane[i].neg  = 1'b0;
      iss.lane[i].a    = {32'd0, ex_tr_r[i]};
    end
    case (ex_cnt_r)
      2'd0, 2'd1, 2'd2: begin
        iss.scale = ex_sc_r[ex_cnt_r];
        for (int i = 0; i < 3; i++) begin
          iss.lane[i].a    = ex_mag_r[ex_cnt_r * 3 + i];
          iss.lane[i].neg  = ex_neg_r[ex_cnt_r * 3 + i];
          iss.lane[i].diag = (i == int'(ex_cnt_r));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/qtm_div.sv -----
// Restoring divider pipeline: one quotient bit per stage for three lanes, then rounding.
module qtm_div import qtm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic col_en,
  input  logic iss_valid,
  input  col_t iss,
  output logic rnd_valid,
  output col_t rnd
);

  col_t pipe_r [DIV_STEPS+1];
  logic [DIV_STEPS:0] v_r;
  col_t rnd_r;
  logic rnd_v_r;
  col_t rnd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      rnd_v_r <= 1'b0;
    end else if (col_en) begin
      v_r     <= {v_r[DIV_STEPS-1:0], iss_valid};
      rnd_v_r <= v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (col_en) pipe_r[0] <= iss;
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
    col_t stp;
    always_comb begin
      stp = pipe_r[j-1];
      if (!pipe_r[j-1].pass) begin
        for (int i = 0; i < 3; i++) begin
          stp.lane[i] = div_step(pipe_r[j-1].lane[i], pipe_r[j-1].n, (j <= 2));
        end
      end
    end
    always_ff @(posedge clk) begin
      if (col_en) pipe_r[j] <= stp;
    end
  end

  // round half away from zero on the magnitude
  always_comb begin
    rnd_nxt = pipe_r[DIV_STEPS];
    if (!rnd_nxt.pass) begin
      for (int i = 0; i < 3; i++) begin
        if ({rnd_nxt.lane[i].a[62:0], 1'b0} >= rnd_nxt.n)
          rnd_nxt.lane[i].q = rnd_nxt.lane[i].q + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (col_en) rnd_r <= rnd_nxt;
  end

  assign rnd_valid = rnd_v_r;
  assign rnd       = rnd_r;

endmodule

// ----- design/qtm_scale.sv -----
// Entry forming, scale multiply, rounding and saturation into the output register.
module qtm_scale import qtm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        col_en,
  input  logic        rnd_valid,
  input  col_t        rnd,
  output logic        out_valid,
  output logic [31:0] out_column_x,
  output logic [31:0] out_column_y,
  output logic [31:0] out_column_z,
  output logic [1:0]  out_column_index,
  output logic        out_last_column,
  output logic        out_zero_rotation
);

  localparam logic signed [EW-1:0] ONE_E = EW'(1 << FRAC_BITS);
  localparam logic signed [PW-1:0] HALF  = PW'(1 << (FRAC_BITS - 1));

  ent_t  ent_r, ent_nxt;
  prod_t mul_r, mul_nxt;
  logic  ent_v_r, mul_v_r, out_v_r;
  logic [2:0][31:0] col_r, col_nxt;
  logic [1:0] idx_r;
  logic       zero_r;

  logic signed [EW-1:0] qe [3];
  logic signed [PW-1:0] s  [3];
  logic signed [RW-1:0] r  [3];

  always_comb begin
    ent_nxt.scale = rnd.scale;
    ent_nxt.idx   = rnd.idx;
    ent_nxt.zero  = rnd.zero;
    ent_nxt.pass  = rnd.pass;
    for (int i = 0; i < 3; i++) begin
      qe[i] = $signed({1'b0, rnd.lane[i].q});
      ent_nxt.tr[i] = rnd.lane[i].a[31:0];
      if (rnd.lane[i].diag)     ent_nxt.e[i] = ONE_E - qe[i];
      else if (rnd.lane[i].neg) ent_nxt.e[i] = -qe[i];
      else                      ent_nxt.e[i] = qe[i];
    end
  end

  always_comb begin
    mul_nxt.idx  = ent_r.idx;
    mul_nxt.zero = ent_r.zero;
    mul_nxt.pass = ent_r.pass;
    mul_nxt.tr   = ent_r.tr;
    for (int i = 0; i < 3; i++) begin
      mul_nxt.p[i] = PW'($signed(ent_r.e[i])) * PW'($signed(ent_r.scale));
    end
  end

  // round half up, then clamp to 32-bit signed
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s[i] = $signed(mul_r.p[i]) + HALF;
      r[i] = s[i][PW-1:FRAC_BITS];
      if (mul_r.zero)
        col_nxt[i] = 32'd0;
      else if (mul_r.pass)
        col_nxt[i] = mul_r.tr[i];
      else if (r[i][RW-1:31] == '0 || r[i][RW-1:31] == '1)
        col_nxt[i] = r[i][31:0];
      else if (r[i][RW-1])
        col_nxt[i] = 32'h8000_0000;
      else
        col_nxt[i] = 32'h7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r <= 1'b0;
      mul_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (col_en) begin
      ent_v_r <= rnd_valid;
      mul_v_r <= ent_v_r;
      out_v_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (col_en) begin
      ent_r  <= ent_nxt;
      mul_r  <= mul_nxt;
      col_r  <= col_nxt;
      idx_r  <= mul_r.idx;
      zero_r <= mul_r.zero;
    end
  end

  assign out_valid         = out_v_r;
  assign out_column_x      = col_r[0];
  assign out_column_y      = col_r[1];
  assign out_column_z      = col_r[2];
  assign out_column_index  = idx_r;
  assign out_last_column   = (idx_r == COL_LAST);
  assign out_zero_rotation = zero_r;

endmodule

// ----- design/quaternion_trs_to_matrix_unit.sv -----
// Top level of the quaternion TRS to column-major matrix unit.
//
//   channel   direction  handshake             payload
//   in_       request    in_valid / in_ready   translate, quat, scale (10 x 32 bit Q16.16)
//   out_      result     out_valid / out_ready column x/y/z, index, last, zero flag
//
// Each request yields four results, one per cycle while out_ready stays high, so
// the output channel sets how often a request is taken.
// From request to first column a request passes four item stages, the column
// issue register, the divider input register, FRAC_BITS + 2 divider stages,
// rounding, entry, multiply and the output register.
// Reset (rst_n low, synchronous) clears all valid bits; no clearing pass.
// A stalled output freezes the whole column pipeline; item stages keep filling.
module quaternion_trs_to_matrix_unit import qtm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_translate_x,
  input  logic [31:0] in_translate_y,
  input  logic [31:0] in_translate_z,
  input  logic [31:0] in_quat_x,
  input  logic [31:0] in_quat_y,
  input  logic [31:0] in_quat_z,
  input  logic [31:0] in_quat_w,
  input  logic [31:0] in_scale_x,
  input  logic [31:0] in_scale_y,
  input  logic [31:0] in_scale_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_column_x,
  output logic [31:0] out_column_y,
  output logic [31:0] out_column_z,
  output logic [1:0]  out_column_index,
  output logic        out_last_column,
  output logic        out_zero_rotation
);

  logic col_en;
  logic iss_valid, rnd_valid;
  col_t iss, rnd;

  // advance the column pipeline unless a finished result is held
  assign col_en = !out_valid || out_ready;

  qtm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_translate_x (in_translate_x),
    .in_translate_y (in_translate_y),
    .in_translate_z (in_translate_z),
    .in_quat_x      (in_quat_x),
    .in_quat_y      (in_quat_y),
    .in_quat_z      (in_quat_z),
    .in_quat_w      (in_quat_w),
    .in_scale_x     (in_scale_x),
    .in_scale_y     (in_scale_y),
    .in_scale_z     (in_scale_z),
    .col_en         (col_en),
    .iss_valid      (iss_valid),
    .iss            (iss)
  );

  qtm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .col_en    (col_en),
    .iss_valid (iss_valid),
    .iss       (iss),
    .rnd_valid (rnd_valid),
    .rnd       (rnd)
  );

  qtm_scale u_scale (
    .clk               (clk),
    .rst_n             (rst_n),
    .col_en            (col_en),
    .rnd_valid         (rnd_valid),
    .rnd               (rnd),
    .out_valid         (out_valid),
    .out_column_x      (out_column_x),
    .out_column_y      (out_column_y),
    .out_column_z      (out_column_z),
    .out_column_index  (out_column_index),
    .out_last_column   (out_last_column),
    .out_zero_rotation (out_zero_rotation)
  );

endmodule

// ----- design/qtm_checker.sv -----
// Port-level checks for the TRS to matrix unit, bound to the top level.
module qtm_checker import qtm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_column_x,
  input logic [31:0] out_column_y,
  input logic [31:0] out_column_z,
  input logic [1:0]  out_column_index,
  input logic        out_last_column,
  input logic        out_zero_rotation
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_column_x)
      && $stable(out_column_index))
    else $error("result changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_column == (out_column_index == COL_LAST)))
    else $error("last flag does not match column index");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_rotation |->
      out_column_x == 32'd0 && out_column_y == 32'd0 && out_column_z == 32'd0)
    else $error("zero rotation with nonzero column");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=>
      !out_valid || out_column_index == 2'($past(out_column_index) + 2'd1))
    else $error("column out of order");

endmodule

bind quaternion_trs_to_matrix_unit qtm_checker u_qtm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_column_x      (out_column_x),
  .out_column_y      (out_column_y),
  .out_column_z      (out_column_z),
  .out_column_index  (out_column_index),
  .out_last_column   (out_last_column),
  .out_zero_rotation (out_zero_rotation)
);
